// ===== sv/pfb_pkg.sv =====
`timescale 1ns / 1ps

package pfb_pkg;

	localparam logic [2:0] CMD_CLEAR   = 3'd0;
	localparam logic [2:0] CMD_PIXEL   = 3'd1;
	localparam logic [2:0] CMD_OUTLINE = 3'd2;
	localparam logic [2:0] CMD_FILL    = 3'd3;
	localparam logic [2:0] CMD_FLUSH   = 3'd4;
	localparam logic [2:0] CMD_NEXT    = 3'd5;

	localparam int INIT_LEN = 25;

	localparam logic [7:0] PAGE_CMD_BASE = 8'hB0;
	localparam logic [7:0] COL_LOW_CMD   = 8'h00;
	localparam logic [7:0] COL_HIGH_CMD  = 8'h10;

	typedef enum logic [1:0] {
		PH_INIT,
		PH_CMD,
		PH_DATA
	} phase_t;

	typedef enum logic [1:0] {
		DR_PIXEL,
		DR_OUTLINE,
		DR_FILL
	} draw_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_GEN,
		ST_WR,
		ST_PUSH
	} state_t;

	function automatic logic [7:0] init_byte(input logic [4:0] idx);
		logic [7:0] b;
		case (idx)
			5'd0:    b = 8'hAE;
			5'd1:    b = 8'hD5;
			5'd2:    b = 8'h80;
			5'd3:    b = 8'hA8;
			5'd4:    b = 8'h3F;
			5'd5:    b = 8'hD3;
			5'd6:    b = 8'h00;
			5'd7:    b = 8'h40;
			5'd8:    b = 8'h20;
			5'd9:    b = 8'h00;
			5'd10:   b = 8'hA1;
			5'd11:   b = 8'hC8;
			5'd12:   b = 8'hDA;
			5'd13:   b = 8'h12;
			5'd14:   b = 8'h81;
			5'd15:   b = 8'h7F;
			5'd16:   b = 8'hD9;
			5'd17:   b = 8'hF1;
			5'd18:   b = 8'hDB;
			5'd19:   b = 8'h40;
			5'd20:   b = 8'hA4;
			5'd21:   b = 8'hA6;
			5'd22:   b = 8'h8D;
			5'd23:   b = 8'h14;
			default: b = 8'hAF;
		endcase
		return b;
	endfunction

endpackage

// ===== sv/pfb_if.sv =====
`timescale 1ns / 1ps

interface pfb_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] cmd;
	logic [7:0] pos_x;
	logic [7:0] pos_y;
	logic [7:0] rect_width;
	logic [7:0] rect_height;
	logic       pixel_on;

	modport source (
		output valid, cmd, pos_x, pos_y, rect_width, rect_height, pixel_on,
		input  ready
	);
	modport sink (
		input  valid, cmd, pos_x, pos_y, rect_width, rect_height, pixel_on,
		output ready
	);
endinterface

interface pfb_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] spi_byte;
	logic       is_data;
	logic       frame_end;
	logic       stream_end;

	modport source (
		output valid, spi_byte, is_data, frame_end, stream_end,
		input  ready
	);
	modport sink (
		input  valid, spi_byte, is_data, frame_end, stream_end,
		output ready
	);
endinterface

// ===== sv/pfb_ram.sv =====
`timescale 1ns / 1ps

module pfb_ram #(
	parameter int DATA_W = 8,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic              re,
	input  logic [AW-1:0]     addr,
	input  logic [DATA_W-1:0] wdata,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

// ===== sv/page_framebuffer_draw_and_flush_top.sv =====
`timescale 1ns / 1ps
// Page-organised monochrome frame store with a byte stream for the panel controller.
// The item channel takes drawing commands (clear, pixel, outline or filled rectangle),
// a start-flush command and next-byte requests; each transfer is one command.
// The result channel gives one byte per next-byte request while a flush runs.
// All drawing goes through one read-modify-write unit on a single-port store.
// A pixel command reads its store byte in a generate step and writes it back in a
// write step; an off-screen pixel is only checked in the generate step. A rectangle
// has a generate step per pixel it visits and a write step per visible pixel.
// A clear writes zero to every store byte. A next-byte request during a flush waits in
// a push state until the result register is free and its byte is registered there;
// a data byte is read from the store in the cycle in which the request is taken.
// The item channel is not ready while a command is being worked on.
// After reset the store is cleared in a pass over every address, during which
// no item is taken; init bytes are then pending for the first flush.
// A stalled receiver holds the result register; drawing commands are still taken,
// but a further next-byte request holds the item channel until the register empties.
module page_framebuffer_draw_and_flush_top
	import pfb_pkg::*;
#(
	parameter int WIDTH = 128,
	parameter int PAGES = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	pfb_in_if.sink    item,
	pfb_out_if.source result
);

	localparam int DEPTH = WIDTH * PAGES;
	localparam int AW = $clog2(DEPTH);

	state_t state_q, state_d;

	draw_t      kind_q;
	logic [7:0] x_q, y_q, xe_q, ye_q, wm1_q, hm1_q;
	logic [7:0] col_q, row_q;
	logic [1:0] seg_q;
	logic       on_q, set_q, last_q;
	logic [AW-1:0] addr_q, clr_q;
	logic [7:0] mask_q;

	logic       init_pending_q, flush_active_q;
	phase_t     phase_q;
	logic [2:0] page_q;
	logic [6:0] pos_q;

	logic [7:0] res_byte_q;
	logic       res_data_q, res_fe_q, res_se_q, use_ram_q;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_data_q, out_fe_q, out_se_q;

	logic          ram_we, ram_re;
	logic [AW-1:0] ram_addr;
	logic [7:0]    ram_wdata, ram_rdata;

	logic       acc, slot_free, clr_done;
	logic [7:0] ax, ox, ay, oy, px, py, lim;
	logic       onscr, col_end, gen_last;
	logic [10:0] gen_addr_w, flush_addr_w;

	pfb_ram #(
		.DATA_W(8),
		.DEPTH (DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.re   (ram_re),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	assign acc = item.valid && item.ready;
	assign slot_free = !out_valid_q || result.ready;
	assign clr_done = (clr_q == AW'(DEPTH - 1));

	always_comb begin
		ax = x_q;
		ox = 8'd0;
		ay = y_q;
		oy = 8'd0;
		unique case (kind_q)
			DR_FILL: begin
				ox = col_q;
				oy = row_q;
			end
			DR_OUTLINE: begin
				case (seg_q)
					2'd0: ox = col_q;
					2'd1: begin
						ox = col_q;
						ay = ye_q;
					end
					2'd2: oy = col_q;
					default: begin
						ax = xe_q;
						oy = col_q;
					end
				endcase
			end
			default: begin
			end
		endcase
		px = ax + ox;
		py = ay + oy;
		onscr = ({1'b0, px} < 9'(WIDTH)) && ({1'b0, py} < 9'(PAGES * 8));
		gen_addr_w = 11'(py[7:3]) * 11'(WIDTH) + 11'(px);
		flush_addr_w = 11'(page_q) * 11'(WIDTH) + 11'(pos_q);
		lim = seg_q[1] ? hm1_q : wm1_q;
		col_end = 1'b0;
		gen_last = 1'b1;
		unique case (kind_q)
			DR_FILL: begin
				col_end = (col_q == wm1_q);
				gen_last = col_end && (row_q == hm1_q);
			end
			DR_OUTLINE: begin
				col_end = (col_q == lim);
				gen_last = col_end && (seg_q == 2'd3);
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (acc) begin
					unique case (item.cmd) inside
						CMD_CLEAR: state_d = ST_CLEAR;
						CMD_PIXEL: state_d = ST_GEN;
						CMD_OUTLINE, CMD_FILL: begin
							if (item.rect_width != 8'd0 && item.rect_height != 8'd0) begin
								state_d = ST_GEN;
							end
						end
						CMD_NEXT: begin
							if (flush_active_q) begin
								state_d = ST_PUSH;
							end
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_GEN: begin
				if (onscr) begin
					state_d = ST_WR;
				end else if (gen_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_WR: state_d = last_q ? ST_IDLE : ST_GEN;
			ST_PUSH: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		item.ready = 1'b0;
		ram_we = 1'b0;
		ram_re = 1'b0;
		ram_addr = addr_q;
		ram_wdata = 8'd0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
				ram_addr = clr_q;
			end
			ST_IDLE: begin
				item.ready = 1'b1;
				if (item.valid && item.cmd == CMD_NEXT && flush_active_q && phase_q == PH_DATA) begin
					ram_re = 1'b1;
					ram_addr = flush_addr_w[AW-1:0];
				end
			end
			ST_GEN: begin
				ram_re = onscr;
				ram_addr = gen_addr_w[AW-1:0];
			end
			ST_WR: begin
				ram_we = 1'b1;
				ram_wdata = set_q ? (ram_rdata | mask_q) : (ram_rdata & ~mask_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			init_pending_q <= 1'b1;
			flush_active_q <= 1'b0;
			phase_q <= PH_INIT;
			page_q <= 3'd0;
			pos_q <= 7'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_PUSH && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: clr_q <= clr_done ? '0 : clr_q + 1'b1;
				ST_IDLE: begin
					if (acc) begin
						case (item.cmd) inside
							CMD_PIXEL: begin
								kind_q <= DR_PIXEL;
								x_q <= item.pos_x;
								y_q <= item.pos_y;
								on_q <= item.pixel_on;
							end
							CMD_OUTLINE, CMD_FILL: begin
								kind_q <= (item.cmd == CMD_FILL) ? DR_FILL : DR_OUTLINE;
								x_q <= item.pos_x;
								y_q <= item.pos_y;
								xe_q <= item.pos_x + item.rect_width - 8'd1;
								ye_q <= item.pos_y + item.rect_height - 8'd1;
								wm1_q <= item.rect_width - 8'd1;
								hm1_q <= item.rect_height - 8'd1;
								col_q <= 8'd0;
								row_q <= 8'd0;
								seg_q <= 2'd0;
								on_q <= 1'b1;
							end
							CMD_FLUSH: begin
								flush_active_q <= 1'b1;
								phase_q <= init_pending_q ? PH_INIT : PH_CMD;
								page_q <= 3'd0;
								pos_q <= 7'd0;
							end
							CMD_NEXT: begin
								if (flush_active_q) begin
									res_data_q <= 1'b0;
									res_fe_q <= 1'b0;
									res_se_q <= 1'b0;
									use_ram_q <= 1'b0;
									case (phase_q)
										PH_INIT: begin
											res_byte_q <= init_byte(
												(pos_q < 7'(INIT_LEN - 1)) ?
												pos_q[4:0] : 5'(INIT_LEN - 1));
											if (pos_q >= 7'(INIT_LEN - 1)) begin
												res_fe_q <= 1'b1;
												init_pending_q <= 1'b0;
												phase_q <= PH_CMD;
												pos_q <= 7'd0;
											end else begin
												pos_q <= pos_q + 7'd1;
											end
										end
										PH_CMD: begin
											if (pos_q == 7'd0) begin
												res_byte_q <= PAGE_CMD_BASE + 8'(page_q);
											end else if (pos_q == 7'd1) begin
												res_byte_q <= COL_LOW_CMD;
											end else begin
												res_byte_q <= COL_HIGH_CMD;
											end
											if (pos_q >= 7'd2) begin
												res_fe_q <= 1'b1;
												phase_q <= PH_DATA;
												pos_q <= 7'd0;
											end else begin
												pos_q <= pos_q + 7'd1;
											end
										end
										default: begin
											res_data_q <= 1'b1;
											use_ram_q <= 1'b1;
											if (pos_q == 7'(WIDTH - 1)) begin
												res_fe_q <= 1'b1;
												pos_q <= 7'd0;
												if (page_q == 3'(PAGES - 1)) begin
													res_se_q <= 1'b1;
													flush_active_q <= 1'b0;
													phase_q <= PH_INIT;
													page_q <= 3'd0;
												end else begin
													page_q <= page_q + 3'd1;
													phase_q <= PH_CMD;
												end
											end else begin
												pos_q <= pos_q + 7'd1;
											end
										end
									endcase
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_GEN: begin
					if (onscr) begin
						addr_q <= gen_addr_w[AW-1:0];
						mask_q <= 8'd1 << py[2:0];
						set_q <= on_q;
						last_q <= gen_last;
					end
					if (kind_q != DR_PIXEL) begin
						if (col_end) begin
							col_q <= 8'd0;
							if (kind_q == DR_FILL) begin
								row_q <= row_q + 8'd1;
							end else begin
								seg_q <= seg_q + 2'd1;
							end
						end else begin
							col_q <= col_q + 8'd1;
						end
					end
				end
				ST_PUSH: begin
					if (slot_free) begin
						out_byte_q <= use_ram_q ? ram_rdata : res_byte_q;
						out_data_q <= res_data_q;
						out_fe_q <= res_fe_q;
						out_se_q <= res_se_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign result.valid = out_valid_q;
	assign result.spi_byte = out_byte_q;
	assign result.is_data = out_data_q;
	assign result.frame_end = out_fe_q;
	assign result.stream_end = out_se_q;

	a_store_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we || ram_re) |-> (32'(ram_addr) < DEPTH))
		else $error("frame store address out of range");

	a_data_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && item.cmd == CMD_NEXT && flush_active_q && phase_q == PH_DATA)
		|=> (state_q == ST_PUSH && use_ram_q && res_data_q))
		else $error("data byte request did not fetch from the store");

	a_init_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(init_pending_q) |-> ($past(phase_q) == PH_INIT && state_q == ST_PUSH))
		else $error("init pending cleared outside the init phase");

	a_no_write_on_push: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PUSH && use_ram_q) |-> !ram_we && !ram_re)
		else $error("store accessed while a fetched byte is held");

endmodule

// ===== dv/pfb_stream_checker.sv =====
`timescale 1ns / 1ps

module pfb_stream_checker
	import pfb_pkg::*;
#(
	parameter int WIDTH = 128,
	parameter int PAGES = 8
) (
	input  logic clk,
	input  logic arst_n,
	pfb_in_if    item,
	pfb_out_if   result,
	output int   fail_count,
	output int   pending
);

	localparam int INIT_BYTES = 25;
	localparam logic [8*INIT_BYTES-1:0] PANEL_INIT = {
		8'hAE, 8'hD5, 8'h80, 8'hA8, 8'h3F, 8'hD3, 8'h00, 8'h40,
		8'h20, 8'h00, 8'hA1, 8'hC8, 8'hDA, 8'h12, 8'h81, 8'h7F,
		8'hD9, 8'hF1, 8'hDB, 8'h40, 8'hA4, 8'hA6, 8'h8D, 8'h14,
		8'hAF
	};
	localparam logic [7:0] PAGE_ADDR_BASE = 8'hB0;
	localparam logic [7:0] COL_LOW_ADDR   = 8'h00;
	localparam logic [7:0] COL_HIGH_ADDR  = 8'h10;

	typedef enum logic [1:0] {
		SEND_INIT,
		SEND_ADDR,
		SEND_DATA
	} stream_stage_t;

	typedef struct packed {
		logic [7:0] spi_byte;
		logic       is_data;
		logic       frame_end;
		logic       stream_end;
	} panel_byte_t;

	logic [7:0]    shadow [WIDTH*PAGES];
	logic          init_due;
	logic          streaming;
	stream_stage_t stage;
	logic [2:0]    page;
	logic [7:0]    col;
	panel_byte_t   due_bytes [$];

	function automatic void wipe();
		for (int k = 0; k < WIDTH * PAGES; k++) begin
			shadow[k] = 8'h00;
		end
	endfunction

	function automatic void plot(input logic [7:0] x, input logic [7:0] y, input logic lit);
		int idx;
		if (int'(x) < WIDTH && int'(y) < PAGES * 8) begin
			idx = int'(x) + int'(y[7:3]) * WIDTH;
			if (lit) begin
				shadow[idx] = shadow[idx] | (8'd1 << y[2:0]);
			end else begin
				shadow[idx] = shadow[idx] & ~(8'd1 << y[2:0]);
			end
		end
	endfunction

	function automatic void draw_outline(input logic [7:0] x, input logic [7:0] y,
			input logic [7:0] w, input logic [7:0] h);
		logic [7:0] right;
		logic [7:0] bottom;
		int         i;
		right = x + w - 8'd1;
		bottom = y + h - 8'd1;
		if (w != 8'd0 && h != 8'd0) begin
			for (i = 0; i < int'(w); i++) begin
				plot(x + i[7:0], y, 1'b1);
				plot(x + i[7:0], bottom, 1'b1);
			end
			for (i = 0; i < int'(h); i++) begin
				plot(x, y + i[7:0], 1'b1);
				plot(right, y + i[7:0], 1'b1);
			end
		end
	endfunction

	function automatic void draw_fill(input logic [7:0] x, input logic [7:0] y,
			input logic [7:0] w, input logic [7:0] h);
		int r;
		int c;
		for (r = 0; r < int'(h); r++) begin
			for (c = 0; c < int'(w); c++) begin
				plot(x + c[7:0], y + r[7:0], 1'b1);
			end
		end
	endfunction

	function automatic panel_byte_t next_stream_byte();
		panel_byte_t o;
		o = '0;
		case (stage)
			SEND_INIT: begin
				o.spi_byte = PANEL_INIT[(INIT_BYTES - 1 - int'(col)) * 8 +: 8];
				if (int'(col) == INIT_BYTES - 1) begin
					o.frame_end = 1'b1;
					init_due = 1'b0;
					stage = SEND_ADDR;
					col = 8'd0;
				end else begin
					col = col + 8'd1;
				end
			end
			SEND_ADDR: begin
				if (col == 8'd0) begin
					o.spi_byte = PAGE_ADDR_BASE + {5'd0, page};
				end else if (col == 8'd1) begin
					o.spi_byte = COL_LOW_ADDR;
				end else begin
					o.spi_byte = COL_HIGH_ADDR;
				end
				if (col >= 8'd2) begin
					o.frame_end = 1'b1;
					stage = SEND_DATA;
					col = 8'd0;
				end else begin
					col = col + 8'd1;
				end
			end
			default: begin
				o.is_data = 1'b1;
				o.spi_byte = shadow[int'(page) * WIDTH + int'(col)];
				if (int'(col) == WIDTH - 1) begin
					o.frame_end = 1'b1;
					col = 8'd0;
					if (int'(page) == PAGES - 1) begin
						o.stream_end = 1'b1;
						streaming = 1'b0;
						stage = SEND_INIT;
						page = 3'd0;
					end else begin
						page = page + 3'd1;
						stage = SEND_ADDR;
					end
				end else begin
					col = col + 8'd1;
				end
			end
		endcase
		return o;
	endfunction

	function automatic void apply_command(input logic [2:0] op, input logic [7:0] x,
			input logic [7:0] y, input logic [7:0] w, input logic [7:0] h, input logic lit);
		case (op)
			CMD_CLEAR:   wipe();
			CMD_PIXEL:   plot(x, y, lit);
			CMD_OUTLINE: draw_outline(x, y, w, h);
			CMD_FILL:    draw_fill(x, y, w, h);
			CMD_FLUSH: begin
				streaming = 1'b1;
				stage = init_due ? SEND_INIT : SEND_ADDR;
				page = 3'd0;
				col = 8'd0;
			end
			CMD_NEXT: begin
				if (streaming) begin
					due_bytes.push_back(next_stream_byte());
				end
			end
			default: ;
		endcase
	endfunction

	task automatic check_field(input string what, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
		end
	endtask

	task automatic compare_byte();
		panel_byte_t want;
		if (due_bytes.size() == 0) begin
			fail_count++;
			$display("%0t: unexpected transfer, expected none, actual byte %h dc %b fe %b se %b",
				$time, result.spi_byte, result.is_data, result.frame_end, result.stream_end);
		end else begin
			want = due_bytes.pop_front();
			check_field("spi_byte", want.spi_byte, result.spi_byte);
			check_field("is_data", {7'd0, want.is_data}, {7'd0, result.is_data});
			check_field("frame_end", {7'd0, want.frame_end}, {7'd0, result.frame_end});
			check_field("stream_end", {7'd0, want.stream_end}, {7'd0, result.stream_end});
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wipe();
			init_due = 1'b1;
			streaming = 1'b0;
			stage = SEND_INIT;
			page = 3'd0;
			col = 8'd0;
			due_bytes.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (result.valid && result.ready) begin
				compare_byte();
			end
			if (item.valid && item.ready) begin
				apply_command(item.cmd, item.pos_x, item.pos_y, item.rect_width,
					item.rect_height, item.pixel_on);
			end
			pending = due_bytes.size();
		end
	end

endmodule

// ===== dv/page_framebuffer_draw_and_flush_top_tb.sv =====
`timescale 1ns / 1ps

module page_framebuffer_draw_and_flush_top_tb;
	import pfb_pkg::*;

	localparam int WIDTH = 128;
	localparam int PAGES = 8;
	localparam int STALL_LIMIT = 400000;
	localparam int ITEM_GOAL = 650;
	localparam int CALM_ITEMS = 60;
	localparam logic [2:0] CMD_SPARE_A = 3'd6;
	localparam logic [2:0] CMD_SPARE_B = 3'd7;

	logic clk;
	logic arst_n;
	bit   calm;
	bit   gappy;
	int   fail_count;
	int   pending;
	int   items_sent;
	int   quiet_cycles = 0;

	pfb_in_if  item ();
	pfb_out_if result ();

	page_framebuffer_draw_and_flush_top #(
		.WIDTH(WIDTH),
		.PAGES(PAGES)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item),
		.result(result)
	);

	pfb_stream_checker #(
		.WIDTH(WIDTH),
		.PAGES(PAGES)
	) checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.result    (result),
		.fail_count(fail_count),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((item.valid && item.ready) || (result.valid && result.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// The receiver stalls in bursts, except during the closing stretch of the run.
	initial begin
		result.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				result.ready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(negedge clk);
			end
			result.ready <= 1'b1;
			repeat ($urandom_range(0, 24)) @(negedge clk);
		end
	end

	task automatic send(input logic [2:0] op, input logic [7:0] x, input logic [7:0] y,
			input logic [7:0] w, input logic [7:0] h, input logic lit);
		int gap;
		gap = 0;
		if (!calm && gappy && $urandom_range(0, 2) == 0) begin
			gap = $urandom_range(1, 13);
		end
		@(negedge clk);
		if (gap > 0) begin
			item.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item.valid <= 1'b1;
		item.cmd <= op;
		item.pos_x <= x;
		item.pos_y <= y;
		item.rect_width <= w;
		item.rect_height <= h;
		item.pixel_on <= lit;
		do @(posedge clk); while (!item.ready);
		items_sent++;
	endtask

	task automatic send_bare(input logic [2:0] op);
		send(op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			1'($urandom_range(0, 1)));
	endtask

	function automatic logic [7:0] rand_coord(input int span);
		if ($urandom_range(0, 99) < 35) begin
			return 8'($urandom_range(0, 255));
		end
		return 8'($urandom_range(0, span + 3));
	endfunction

	function automatic logic [7:0] rand_extent();
		if ($urandom_range(0, 39) == 0) begin
			return 8'($urandom_range(0, 255));
		end
		return 8'($urandom_range(0, 16));
	endfunction

	task automatic random_draw();
		int         pick;
		logic [2:0] op;
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			op = CMD_PIXEL;
		end else if (pick < 66) begin
			op = CMD_OUTLINE;
		end else if (pick < 88) begin
			op = CMD_FILL;
		end else if (pick < 92) begin
			op = CMD_CLEAR;
		end else begin
			op = $urandom_range(0, 1) ? CMD_SPARE_A : CMD_SPARE_B;
		end
		send(op, rand_coord(WIDTH), rand_coord(PAGES * 8), rand_extent(), rand_extent(),
			1'($urandom_range(0, 1)));
	endtask

	task automatic stream_frame(input int nexts, input int draw_pct);
		send_bare(CMD_FLUSH);
		for (int i = 0; i < nexts; i++) begin
			if ($urandom_range(0, 99) < draw_pct) begin
				random_draw();
			end
			send_bare(CMD_NEXT);
		end
	endtask

	initial begin
		int pick;
		int budget;
		int nexts;
		arst_n = 1'b0;
		calm = 1'b0;
		gappy = 1'b1;
		items_sent = 0;
		item.valid = 1'b0;
		item.cmd = CMD_CLEAR;
		item.pos_x = 8'd0;
		item.pos_y = 8'd0;
		item.rect_width = 8'd0;
		item.rect_height = 8'd0;
		item.pixel_on = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_bare(CMD_NEXT);
		send(CMD_FILL, 8'd0, 8'd0, 8'd255, 8'd255, 1'b0);
		send_bare(CMD_CLEAR);
		send(CMD_PIXEL, 8'd0, 8'd0, 8'd7, 8'd9, 1'b1);
		send(CMD_PIXEL, 8'd127, 8'd63, 8'd0, 8'd0, 1'b1);
		send(CMD_PIXEL, 8'd128, 8'd5, 8'd1, 8'd1, 1'b1);
		send(CMD_PIXEL, 8'd3, 8'd64, 8'd1, 8'd1, 1'b1);
		send(CMD_PIXEL, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
		send(CMD_PIXEL, 8'd127, 8'd63, 8'd3, 8'd3, 1'b0);
		send(CMD_OUTLINE, 8'd120, 8'd58, 8'd20, 8'd10, 1'b0);
		send(CMD_OUTLINE, 8'd250, 8'd250, 8'd10, 8'd10, 1'b1);
		send(CMD_OUTLINE, 8'd0, 8'd0, 8'd255, 8'd255, 1'b0);
		send(CMD_OUTLINE, 8'd10, 8'd10, 8'd0, 8'd5, 1'b1);
		send(CMD_FILL, 8'd20, 8'd20, 8'd5, 8'd0, 1'b1);
		send(CMD_FILL, 8'd40, 8'd6, 8'd3, 8'd12, 1'b0);
		send_bare(CMD_SPARE_A);
		send_bare(CMD_SPARE_B);
		send_bare(CMD_FLUSH);
		repeat (3) send_bare(CMD_NEXT);
		send_bare(CMD_FLUSH);
		repeat (2) send_bare(CMD_NEXT);
		send(CMD_PIXEL, 8'd1, 8'd0, 8'd0, 8'd0, 1'b1);

		while (items_sent < ITEM_GOAL - CALM_ITEMS) begin
			gappy = ($urandom_range(0, 2) != 0);
			pick = $urandom_range(0, 99);
			budget = ITEM_GOAL - CALM_ITEMS - items_sent;
			if (pick < 45) begin
				repeat ($urandom_range(1, 6)) random_draw();
			end else if (pick < 90) begin
				nexts = $urandom_range(1, 200);
				if (nexts > budget) begin
					nexts = budget;
				end
				stream_frame(nexts, 10);
			end else begin
				repeat ($urandom_range(1, 5)) send_bare(CMD_NEXT);
			end
		end

		calm = 1'b1;
		stream_frame(CALM_ITEMS - 1, 0);

		@(negedge clk);
		item.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (32) @(negedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ===== files.f =====
sv/pfb_pkg.sv
sv/pfb_if.sv
sv/pfb_ram.sv
sv/page_framebuffer_draw_and_flush_top.sv
dv/pfb_stream_checker.sv
dv/page_framebuffer_draw_and_flush_top_tb.sv
